// ===== hw/rtl/arfc_pkg.sv =====
package arfc_pkg;

   // widths of the result fields
   localparam int OFFSET_BITS    = 17;
   localparam int CODE_BITS      = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;

   // verdict error codes
   localparam logic [CODE_BITS-1:0] ERR_NONE              = 4'd0;
   localparam logic [CODE_BITS-1:0] ERR_SHORT_HEADER      = 4'd1;
   localparam logic [CODE_BITS-1:0] ERR_NO_RESULT         = 4'd2;
   localparam logic [CODE_BITS-1:0] ERR_EXTRA_AFTER_FAIL  = 4'd3;
   localparam logic [CODE_BITS-1:0] ERR_BLOCK_HEADER      = 4'd4;
   localparam logic [CODE_BITS-1:0] ERR_LENGTH_MISMATCH   = 4'd5;
   localparam logic [CODE_BITS-1:0] ERR_NO_COUNT          = 4'd6;
   localparam logic [CODE_BITS-1:0] ERR_LIST_TRUNCATED    = 4'd7;
   localparam logic [CODE_BITS-1:0] ERR_CAUSE_MISSING     = 4'd8;
   localparam logic [CODE_BITS-1:0] ERR_EXTRA_AFTER_LIST  = 4'd9;
   localparam logic [CODE_BITS-1:0] ERR_UNKNOWN_SUBTYPE   = 4'd10;

   // list walker phases
   localparam logic [1:0] PHASE_CHOICE   = 2'd0;
   localparam logic [1:0] PHASE_OPTIONAL = 2'd1;
   localparam logic [1:0] PHASE_CAUSE    = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORMAL_CODE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DATABLOCK_CODE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIST_CODE      = 2'd2;

   // register reset values
   localparam logic [7:0] NORMAL_CODE_RESET    = 8'd1;
   localparam logic [7:0] DATABLOCK_CODE_RESET = 8'd2;
   localparam logic [7:0] LIST_CODE_RESET      = 8'd3;

   // frame layout and byte values
   localparam int         HIGH_PRIORITY_BIT    = 7;
   localparam int         DATABLOCK_HEADER_LEN = 10;
   localparam logic [7:0] FINAL_BLOCK_MARK     = 8'h01;
   localparam logic [7:0] RESULT_SUCCESS       = 8'h00;
   localparam logic [7:0] CHOICE_OPTIONAL      = 8'h00;
   localparam logic [7:0] CHOICE_CAUSE         = 8'h01;

   // per-frame parse state
   typedef struct packed {
      logic [7:0]             subtype;
      logic [7:0]             invoke;
      logic [7:0]             third_field;
      logic [31:0]            block_number;
      logic [15:0]            length;
      logic [7:0]             items_left;
      logic [1:0]             list_phase;
      logic [OFFSET_BITS-1:0] done_offset;
      logic [CODE_BITS-1:0]   list_error;
   } frame_state_type;

   // subtype codes as programmed
   typedef struct packed {
      logic [7:0] normal_code;
      logic [7:0] datablock_code;
      logic [7:0] list_code;
   } subtype_codes_type;

   // one verdict
   typedef struct packed {
      logic                   frame_ok;
      logic [CODE_BITS-1:0]   error_code;
      logic [OFFSET_BITS-1:0] error_offset;
      logic [7:0]             response_subtype;
      logic [7:0]             invoke_id;
      logic                   high_priority;
      logic [7:0]             result_byte;
      logic                   final_block;
      logic [31:0]            block_number;
      logic [15:0]            declared_length;
      logic [7:0]             list_count;
      logic [OFFSET_BITS-1:0] frame_length;
   } verdict_type;

endpackage

// ===== hw/rtl/arfc_req_if.sv =====
interface arfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== hw/rtl/arfc_rsp_if.sv =====
interface arfc_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ok;
   logic [3:0]  error_code;
   logic [16:0] error_offset;
   logic [7:0]  response_subtype;
   logic [7:0]  invoke_id;
   logic        high_priority;
   logic [7:0]  result_byte;
   logic        final_block;
   logic [31:0] block_number;
   logic [15:0] declared_length;
   logic [7:0]  list_count;
   logic [16:0] frame_length;

   modport source (
      output valid, output frame_ok, output error_code, output error_offset,
      output response_subtype, output invoke_id, output high_priority,
      output result_byte, output final_block, output block_number,
      output declared_length, output list_count, output frame_length,
      input ready
   );
   modport sink (
      input valid, input frame_ok, input error_code, input error_offset,
      input response_subtype, input invoke_id, input high_priority,
      input result_byte, input final_block, input block_number,
      input declared_length, input list_count, input frame_length,
      output ready
   );
endinterface

// ===== hw/rtl/arfc_in_stage.sv =====
module arfc_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte,
   input  logic       req_end,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data,
   output logic       byte_end
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       end_ff;

   // the stage frees up when its byte moves on
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture on transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_byte;
         end_ff  <= req_end;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;
   assign byte_end   = end_ff;

endmodule

// ===== hw/rtl/arfc_frame_state.sv =====
module arfc_frame_state
   import arfc_pkg::*;
#(
   parameter int POSITION_BITS = 17
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [7:0]               byte_data,
   input  logic                     byte_end,
   output frame_state_type          state_next,
   output logic [POSITION_BITS-1:0] frame_len
);

   localparam logic [POSITION_BITS-1:0] POS_MAX     = '1;
   localparam logic [POSITION_BITS-1:0] POS_SUBTYPE = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_INVOKE  = POSITION_BITS'(2);
   localparam logic [POSITION_BITS-1:0] POS_THIRD   = POSITION_BITS'(3);
   localparam logic [POSITION_BITS-1:0] POS_BODY    = POSITION_BITS'(4);
   localparam logic [POSITION_BITS-1:0] POS_BLK_END = POSITION_BITS'(7);
   localparam logic [POSITION_BITS-1:0] POS_LEN_END = POSITION_BITS'(9);

   localparam frame_state_type STATE_CLEAR = '{
      subtype:      8'd0,
      invoke:       8'd0,
      third_field:  8'd0,
      block_number: 32'd0,
      length:       16'd0,
      items_left:   8'd0,
      list_phase:   PHASE_CHOICE,
      done_offset:  '0,
      list_error:   ERR_NONE
   };

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   frame_state_type          st_ff, st_in;

   // saturating byte counter
   assign pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;

   // field capture and list walk for the byte at pos_ff
   always_comb begin
      st_in = st_ff;
      if (pos_ff == POS_SUBTYPE) begin
         st_in.subtype = byte_data;
      end else if (pos_ff == POS_INVOKE) begin
         st_in.invoke = byte_data;
      end else if (pos_ff == POS_THIRD) begin
         st_in.third_field = byte_data;
         st_in.items_left  = byte_data;
         st_in.list_phase  = PHASE_CHOICE;
      end else if (pos_ff >= POS_BODY) begin
         if (pos_ff <= POS_BLK_END) begin
            st_in.block_number = {st_ff.block_number[23:0], byte_data};
         end else if (pos_ff <= POS_LEN_END) begin
            st_in.length = {st_ff.length[7:0], byte_data};
         end
         // only the first list error counts
         if (st_ff.list_error == ERR_NONE) begin
            if (st_ff.list_phase == PHASE_CHOICE) begin
               if (st_ff.items_left == 8'd0) begin
                  st_in.list_error  = ERR_EXTRA_AFTER_LIST;
                  st_in.done_offset = OFFSET_BITS'(pos_ff);
               end else begin
                  st_in.items_left = st_ff.items_left - 8'd1;
                  if (byte_data == CHOICE_OPTIONAL) begin
                     st_in.list_phase = PHASE_OPTIONAL;
                  end else if (byte_data == CHOICE_CAUSE) begin
                     st_in.list_phase = PHASE_CAUSE;
                  end else begin
                     st_in.list_phase = PHASE_CHOICE;
                  end
               end
            end else begin
               st_in.list_phase = PHASE_CHOICE;
            end
         end
      end
   end

   // state clears after the final byte of each frame
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         st_ff  <= STATE_CLEAR;
      end else if (advance) begin
         if (byte_end) begin
            pos_ff <= '0;
            st_ff  <= STATE_CLEAR;
         end else begin
            pos_ff <= pos_in;
            st_ff  <= st_in;
         end
      end
   end

   assign state_next = st_in;
   assign frame_len  = pos_in;

   // a finished frame restarts the counter
   assert property (@(posedge clock) disable iff (reset)
      (advance && byte_end) |=> (pos_ff == '0))
      else $error("byte counter not cleared after frame end");

   // the counter moves only with a consumed byte
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pos_ff))
      else $error("byte counter moved without a byte");

endmodule

// ===== hw/rtl/arfc_verdict.sv =====
module arfc_verdict
   import arfc_pkg::*;
#(
   parameter int POSITION_BITS = 17
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  frame_state_type          state_next,
   input  logic [POSITION_BITS-1:0] frame_len,
   input  subtype_codes_type        codes,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output verdict_type              rsp_data
);

   localparam int CMP_BITS = (POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS;

   localparam logic [CMP_BITS-1:0] LEN_HEADER = CMP_BITS'(3);
   localparam logic [CMP_BITS-1:0] LEN_THIRD  = CMP_BITS'(4);
   localparam logic [CMP_BITS-1:0] LEN_BLOCK  = CMP_BITS'(DATABLOCK_HEADER_LEN);
   localparam logic [OFFSET_BITS-1:0] OFF_SUBTYPE = OFFSET_BITS'(1);
   localparam logic [OFFSET_BITS-1:0] OFF_THIRD   = OFFSET_BITS'(3);
   localparam logic [OFFSET_BITS-1:0] OFF_BODY    = OFFSET_BITS'(4);
   localparam logic [OFFSET_BITS-1:0] OFF_LENGTH  = OFFSET_BITS'(8);

   logic [CMP_BITS-1:0]    len_wide;
   logic [CMP_BITS-1:0]    expected_len;
   logic [OFFSET_BITS-1:0] len_out;
   verdict_type            v;
   logic                   valid_ff, valid_in;
   verdict_type            data_ff;

   assign len_wide     = CMP_BITS'(frame_len);
   assign expected_len = LEN_BLOCK + CMP_BITS'(state_next.length);
   assign len_out      = OFFSET_BITS'(frame_len);

   // verdict from the state after the final byte
   always_comb begin
      v = '0;
      v.error_code   = ERR_NONE;
      v.frame_length = len_out;
      if (len_wide < LEN_HEADER) begin
         v.error_code = ERR_SHORT_HEADER;
      end else begin
         v.response_subtype = state_next.subtype;
         v.invoke_id        = state_next.invoke;
         v.high_priority    = state_next.invoke[HIGH_PRIORITY_BIT];
         if (state_next.subtype == codes.normal_code) begin
            if (len_wide < LEN_THIRD) begin
               v.error_code   = ERR_NO_RESULT;
               v.error_offset = OFF_THIRD;
            end else begin
               v.result_byte = state_next.third_field;
               if (state_next.third_field != RESULT_SUCCESS && len_wide > LEN_THIRD) begin
                  v.error_code   = ERR_EXTRA_AFTER_FAIL;
                  v.error_offset = OFF_BODY;
               end
            end
         end else if (state_next.subtype == codes.datablock_code) begin
            if (len_wide < LEN_BLOCK) begin
               v.error_code   = ERR_BLOCK_HEADER;
               v.error_offset = OFF_THIRD;
            end else begin
               v.final_block     = (state_next.third_field == FINAL_BLOCK_MARK);
               v.block_number    = state_next.block_number;
               v.declared_length = state_next.length;
               if (len_wide != expected_len) begin
                  v.error_code   = ERR_LENGTH_MISMATCH;
                  v.error_offset = OFF_LENGTH;
               end
            end
         end else if (state_next.subtype == codes.list_code) begin
            if (len_wide < LEN_THIRD) begin
               v.error_code   = ERR_NO_COUNT;
               v.error_offset = OFF_THIRD;
            end else begin
               v.list_count = state_next.third_field;
               if (state_next.list_error != ERR_NONE) begin
                  v.error_code   = state_next.list_error;
                  v.error_offset = state_next.done_offset;
               end else if (state_next.list_phase == PHASE_CAUSE) begin
                  v.error_code   = ERR_CAUSE_MISSING;
                  v.error_offset = len_out;
               end else if (state_next.items_left != 8'd0) begin
                  v.error_code   = ERR_LIST_TRUNCATED;
                  v.error_offset = len_out;
               end
            end
         end else begin
            v.error_code   = ERR_UNKNOWN_SUBTYPE;
            v.error_offset = OFF_SUBTYPE;
         end
      end
      v.frame_ok = (v.error_code == ERR_NONE);
   end

   // result register
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= v;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hw/rtl/action_response_frame_checker.sv =====
// a frame's final byte passes the input stage register, then loads its verdict into the result register on rsp
// throughput: one byte per cycle; a verdict waiting on rsp stalls only the next final byte
// the per-byte work is one pass of field capture and list walk between two registers
// reset: synchronous, active high; clears the frame state and the pipeline valids,
// and returns the subtype codes to normal 1, data block 2, list 3
module action_response_frame_checker
   import arfc_pkg::*;
#(
   parameter int POSITION_BITS = 17
) (
   input  logic                      clock,
   input  logic                      reset,
   arfc_req_if.sink                  req_if,
   arfc_rsp_if.source                rsp_if,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   subtype_codes_type        codes_ff;
   logic                     byte_valid;
   logic [7:0]               byte_data;
   logic                     byte_end;
   logic                     advance;
   logic                     load;
   frame_state_type          state_next;
   logic [POSITION_BITS-1:0] frame_len;
   logic                     rsp_valid;
   verdict_type              rsp_data;

   // subtype code registers
   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.normal_code    <= NORMAL_CODE_RESET;
         codes_ff.datablock_code <= DATABLOCK_CODE_RESET;
         codes_ff.list_code      <= LIST_CODE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_NORMAL_CODE: begin
               codes_ff.normal_code <= csr_wdata;
            end
            CSR_DATABLOCK_CODE: begin
               codes_ff.datablock_code <= csr_wdata;
            end
            CSR_LIST_CODE: begin
               codes_ff.list_code <= csr_wdata;
            end
            default: begin
               codes_ff <= codes_ff;
            end
         endcase
      end
   end

   // a final byte moves on only when the result register is free
   assign advance = byte_valid && (!byte_end || !rsp_valid || rsp_if.ready);
   assign load    = advance && byte_end;

   arfc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_byte   (req_if.frame_byte),
      .req_end    (req_if.frame_end),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .byte_end   (byte_end)
   );

   arfc_frame_state #(
      .POSITION_BITS (POSITION_BITS)
   ) u_frame_state (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .byte_data  (byte_data),
      .byte_end   (byte_end),
      .state_next (state_next),
      .frame_len  (frame_len)
   );

   arfc_verdict #(
      .POSITION_BITS (POSITION_BITS)
   ) u_verdict (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .state_next (state_next),
      .frame_len  (frame_len),
      .codes      (codes_ff),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   // result channel
   assign rsp_if.valid            = rsp_valid;
   assign rsp_if.frame_ok         = rsp_data.frame_ok;
   assign rsp_if.error_code       = rsp_data.error_code;
   assign rsp_if.error_offset     = rsp_data.error_offset;
   assign rsp_if.response_subtype = rsp_data.response_subtype;
   assign rsp_if.invoke_id        = rsp_data.invoke_id;
   assign rsp_if.high_priority    = rsp_data.high_priority;
   assign rsp_if.result_byte      = rsp_data.result_byte;
   assign rsp_if.final_block      = rsp_data.final_block;
   assign rsp_if.block_number     = rsp_data.block_number;
   assign rsp_if.declared_length  = rsp_data.declared_length;
   assign rsp_if.list_count       = rsp_data.list_count;
   assign rsp_if.frame_length     = rsp_data.frame_length;

   // a new verdict never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      (load && rsp_valid) |-> rsp_if.ready)
      else $error("verdict overwritten before transfer");

   // a verdict appears only after a final byte was consumed
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(load))
      else $error("verdict without a final byte");

   // ok flag agrees with the error code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.frame_ok == (rsp_data.error_code == ERR_NONE)))
      else $error("ok flag disagrees with error code");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import arfc_pkg::*;

   localparam int                     IDLE_PERCENT   = 11;
   localparam int                     HOLDOFF_CYCLES = 300;
   localparam int                     SETTLE_CYCLES  = 4;
   localparam logic [OFFSET_BITS-1:0] POSITION_MAX   = '1;

   // expected verdicts, worked out from the accepted frame bytes
   class verdict_tracker;
      subtype_codes_type codes;
      frame_state_type   st;
      logic [OFFSET_BITS-1:0] position;
      verdict_type       pending_verdicts[$];
      int                failures;

      function new();
         codes.normal_code    = NORMAL_CODE_RESET;
         codes.datablock_code = DATABLOCK_CODE_RESET;
         codes.list_code      = LIST_CODE_RESET;
         failures = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         st = '0;
         st.list_phase = PHASE_CHOICE;
         st.list_error = ERR_NONE;
         position = '0;
      endfunction

      function void set_code(logic [CSR_INDEX_BITS-1:0] idx, logic [7:0] value);
         case (idx)
            CSR_NORMAL_CODE: codes.normal_code = value;
            CSR_DATABLOCK_CODE: codes.datablock_code = value;
            CSR_LIST_CODE: codes.list_code = value;
            default: ;
         endcase
      endfunction

      function int pending_count();
         return pending_verdicts.size();
      endfunction

      // one transfer on the byte channel
      function void note_frame_byte(logic [7:0] value, logic last);
         logic [OFFSET_BITS-1:0] p;
         logic [OFFSET_BITS-1:0] len;
         verdict_type v;
         p = position;
         len = (p != POSITION_MAX) ? p + 1'b1 : p;

         // field capture by offset, list walk from offset 4 on
         if (p == 1) begin
            st.subtype = value;
         end else if (p == 2) begin
            st.invoke = value;
         end else if (p == 3) begin
            st.third_field = value;
            st.items_left = value;
            st.list_phase = PHASE_CHOICE;
         end else if (p >= 4) begin
            if (p <= 7) begin
               st.block_number = {st.block_number[23:0], value};
            end else if (p <= 9) begin
               st.length = {st.length[7:0], value};
            end
            if (st.list_error == ERR_NONE) begin
               if (st.list_phase == PHASE_CHOICE) begin
                  if (st.items_left == 8'd0) begin
                     st.list_error = ERR_EXTRA_AFTER_LIST;
                     st.done_offset = p;
                  end else begin
                     st.items_left = st.items_left - 8'd1;
                     if (value == CHOICE_OPTIONAL) st.list_phase = PHASE_OPTIONAL;
                     else if (value == CHOICE_CAUSE) st.list_phase = PHASE_CAUSE;
                     else st.list_phase = PHASE_CHOICE;
                  end
               end else begin
                  st.list_phase = PHASE_CHOICE;
               end
            end
         end
         position = len;
         if (!last) return;

         // verdict at the final byte
         v = '0;
         v.error_code = ERR_NONE;
         if (len < 3) begin
            v.error_code = ERR_SHORT_HEADER;
         end else begin
            v.response_subtype = st.subtype;
            v.invoke_id = st.invoke;
            v.high_priority = st.invoke[HIGH_PRIORITY_BIT];
            if (st.subtype == codes.normal_code) begin
               if (len < 4) begin
                  v.error_code = ERR_NO_RESULT;
                  v.error_offset = 3;
               end else begin
                  v.result_byte = st.third_field;
                  if (st.third_field != RESULT_SUCCESS && len > 4) begin
                     v.error_code = ERR_EXTRA_AFTER_FAIL;
                     v.error_offset = 4;
                  end
               end
            end else if (st.subtype == codes.datablock_code) begin
               if (len < DATABLOCK_HEADER_LEN) begin
                  v.error_code = ERR_BLOCK_HEADER;
                  v.error_offset = 3;
               end else begin
                  v.final_block = (st.third_field == FINAL_BLOCK_MARK);
                  v.block_number = st.block_number;
                  v.declared_length = st.length;
                  if (32'(len) != 32'(DATABLOCK_HEADER_LEN) + 32'(st.length)) begin
                     v.error_code = ERR_LENGTH_MISMATCH;
                     v.error_offset = 8;
                  end
               end
            end else if (st.subtype == codes.list_code) begin
               if (len < 4) begin
                  v.error_code = ERR_NO_COUNT;
                  v.error_offset = 3;
               end else begin
                  v.list_count = st.third_field;
                  if (st.list_error != ERR_NONE) begin
                     v.error_code = st.list_error;
                     v.error_offset = st.done_offset;
                  end else if (st.list_phase == PHASE_CAUSE) begin
                     v.error_code = ERR_CAUSE_MISSING;
                     v.error_offset = len;
                  end else if (st.items_left != 8'd0) begin
                     v.error_code = ERR_LIST_TRUNCATED;
                     v.error_offset = len;
                  end
               end
            end else begin
               v.error_code = ERR_UNKNOWN_SUBTYPE;
               v.error_offset = 1;
            end
         end
         v.frame_ok = (v.error_code == ERR_NONE);
         v.frame_length = len;
         pending_verdicts.insert(pending_verdicts.size(), v);
         clear_frame();
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      // one transfer on the verdict channel
      function void check_verdict(verdict_type got);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            $error("verdict with no frame waiting for one");
            failures++;
            return;
         end
         want = pending_verdicts.pop_front();
         compare_field("frame_ok", want.frame_ok, got.frame_ok);
         compare_field("error_code", want.error_code, got.error_code);
         compare_field("error_offset", want.error_offset, got.error_offset);
         compare_field("response_subtype", want.response_subtype, got.response_subtype);
         compare_field("invoke_id", want.invoke_id, got.invoke_id);
         compare_field("high_priority", want.high_priority, got.high_priority);
         compare_field("result_byte", want.result_byte, got.result_byte);
         compare_field("final_block", want.final_block, got.final_block);
         compare_field("block_number", want.block_number, got.block_number);
         compare_field("declared_length", want.declared_length, got.declared_length);
         compare_field("list_count", want.list_count, got.list_count);
         compare_field("frame_length", want.frame_length, got.frame_length);
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   arfc_req_if req_if ();
   arfc_rsp_if rsp_if ();

   verdict_tracker verdicts = new();
   logic [7:0]     frame_q[$];
   bit             sender_steady;
   bit             receiver_steady;
   int             holdoff_requests;
   int             holdoff_served;

   action_response_frame_checker DUT (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   initial begin
      #60_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // verdict receiver with random stalls and the long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && holdoff_served != holdoff_requests) begin
            holdoff_served++;
            stall_left = HOLDOFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= receiver_steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // verdict monitor
   always @(posedge clock) begin
      verdict_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.frame_ok         = rsp_if.frame_ok;
         got.error_code       = rsp_if.error_code;
         got.error_offset     = rsp_if.error_offset;
         got.response_subtype = rsp_if.response_subtype;
         got.invoke_id        = rsp_if.invoke_id;
         got.high_priority    = rsp_if.high_priority;
         got.result_byte      = rsp_if.result_byte;
         got.final_block      = rsp_if.final_block;
         got.block_number     = rsp_if.block_number;
         got.declared_length  = rsp_if.declared_length;
         got.list_count       = rsp_if.list_count;
         got.frame_length     = rsp_if.frame_length;
         verdicts.check_verdict(got);
      end
   end

   // one byte transfer, entered and left at a falling edge
   task automatic send_byte(input logic [7:0] value, input logic last);
      while (!sender_steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.frame_byte <= value;
      req_if.frame_end <= last;
      do @(posedge clock); while (!req_if.ready);
      verdicts.note_frame_byte(value, last);
      @(negedge clock);
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // stop offering and wait for every verdict, then let the pipeline settle
   task automatic drain();
      req_if.valid <= 1'b0;
      while (verdicts.pending_count() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_codes(input logic [7:0] normal, input logic [7:0] datablock,
                                input logic [7:0] list);
      drain();
      csr_write_en <= 1'b1;
      csr_index <= CSR_NORMAL_CODE;
      csr_wdata <= normal;
      verdicts.set_code(CSR_NORMAL_CODE, normal);
      @(negedge clock);
      csr_index <= CSR_DATABLOCK_CODE;
      csr_wdata <= datablock;
      verdicts.set_code(CSR_DATABLOCK_CODE, datablock);
      @(negedge clock);
      csr_index <= CSR_LIST_CODE;
      csr_wdata <= list;
      verdicts.set_code(CSR_LIST_CODE, list);
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // frame builders
   task automatic queue_byte(input logic [7:0] value);
      frame_q.insert(frame_q.size(), value);
   endtask

   task automatic begin_frame(input logic [7:0] subtype, input logic [7:0] invoke);
      frame_q.delete();
      queue_byte(8'($urandom));
      queue_byte(subtype);
      queue_byte(invoke);
   endtask

   task automatic add_filler(input int count);
      repeat (count) queue_byte(8'($urandom));
   endtask

   task automatic add_block_header(input logic [7:0] last_mark, input logic [31:0] number,
                                   input logic [15:0] length);
      queue_byte(last_mark);
      queue_byte(number[31:24]);
      queue_byte(number[23:16]);
      queue_byte(number[15:8]);
      queue_byte(number[7:0]);
      queue_byte(length[15:8]);
      queue_byte(length[7:0]);
   endtask

   task automatic add_list_items(input int count);
      repeat (count) begin
         case ($urandom_range(2))
            0: begin
               queue_byte(CHOICE_OPTIONAL);
               queue_byte(8'($urandom));
            end
            1: begin
               queue_byte(CHOICE_CAUSE);
               queue_byte(8'($urandom));
            end
            default: queue_byte(8'($urandom_range(2, 255)));
         endcase
      end
   endtask

   // mostly well-formed frames of each subtype, with broken ones and noise
   task automatic build_random_frame();
      int kind;
      int count;
      kind = $urandom_range(99);
      if (kind < 25) begin
         begin_frame(verdicts.codes.normal_code, 8'($urandom));
         if ($urandom_range(9) != 0) begin
            queue_byte($urandom_range(1) ? RESULT_SUCCESS : 8'($urandom));
         end
         if ($urandom_range(2) == 0) add_filler($urandom_range(1, 4));
      end else if (kind < 50) begin
         begin_frame(verdicts.codes.datablock_code, 8'($urandom));
         count = $urandom_range(0, 12);
         add_block_header($urandom_range(1) ? FINAL_BLOCK_MARK : 8'($urandom),
                          32'($urandom), 16'(count));
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 7)) void'(frame_q.pop_back());
         end else begin
            if ($urandom_range(4) == 0) count = $urandom_range(0, 15);
            add_filler(count);
         end
      end else if (kind < 80) begin
         begin_frame(verdicts.codes.list_code, 8'($urandom));
         count = $urandom_range(0, 6);
         queue_byte(8'(count));
         add_list_items(count);
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(2))
               0: if (frame_q.size() > 4) void'(frame_q.pop_back());
               1: add_filler($urandom_range(1, 3));
               default: queue_byte(CHOICE_CAUSE);
            endcase
         end
      end else if (kind < 90) begin
         begin_frame(8'($urandom), 8'($urandom));
         add_filler($urandom_range(0, 6));
      end else begin
         frame_q.delete();
         add_filler($urandom_range(1, 8));
      end
   endtask

   task automatic run_random(input int byte_budget);
      int sent;
      sent = 0;
      while (sent < byte_budget) begin
         build_random_frame();
         sent += frame_q.size();
         send_frame();
      end
   endtask

   // directed frames, one per case of the checker
   task automatic run_directed();
      int i;
      // short headers
      frame_q = {8'h7E};
      send_frame();
      frame_q = {8'h00, 8'hFF};
      send_frame();
      // normal: no result, success with priority, failure with extra, long success, failure alone
      begin_frame(verdicts.codes.normal_code, 8'h00);
      send_frame();
      begin_frame(verdicts.codes.normal_code, 8'hFF);
      queue_byte(RESULT_SUCCESS);
      send_frame();
      begin_frame(verdicts.codes.normal_code, 8'h80);
      queue_byte(8'hFF);
      queue_byte(8'h00);
      send_frame();
      begin_frame(verdicts.codes.normal_code, 8'h7F);
      queue_byte(RESULT_SUCCESS);
      add_filler(3);
      send_frame();
      begin_frame(verdicts.codes.normal_code, 8'h01);
      queue_byte(8'h0B);
      send_frame();
      // data block: header short, empty final block, length mismatch
      begin_frame(verdicts.codes.datablock_code, 8'h55);
      queue_byte(FINAL_BLOCK_MARK);
      add_filler(5);
      send_frame();
      begin_frame(verdicts.codes.datablock_code, 8'hAA);
      add_block_header(FINAL_BLOCK_MARK, 32'hFFFF_FFFF, 16'd0);
      send_frame();
      begin_frame(verdicts.codes.datablock_code, 8'h12);
      add_block_header(8'h00, 32'h1234_5678, 16'd4);
      add_filler(5);
      send_frame();
      begin_frame(verdicts.codes.datablock_code, 8'h34);
      send_frame();
      // list: no count, empty, extra after empty, mixed items
      begin_frame(verdicts.codes.list_code, 8'h01);
      send_frame();
      begin_frame(verdicts.codes.list_code, 8'h02);
      queue_byte(8'h00);
      send_frame();
      begin_frame(verdicts.codes.list_code, 8'h03);
      queue_byte(8'h00);
      queue_byte(8'hAB);
      send_frame();
      begin_frame(verdicts.codes.list_code, 8'h04);
      queue_byte(8'd3);
      queue_byte(CHOICE_OPTIONAL);
      queue_byte(8'h99);
      queue_byte(CHOICE_CAUSE);
      queue_byte(8'h22);
      queue_byte(8'h07);
      send_frame();
      // list: cause missing, truncated, first error kept, optional byte absent
      begin_frame(verdicts.codes.list_code, 8'h05);
      queue_byte(8'd2);
      queue_byte(8'h05);
      queue_byte(CHOICE_CAUSE);
      send_frame();
      begin_frame(verdicts.codes.list_code, 8'h06);
      queue_byte(8'd4);
      queue_byte(8'h05);
      queue_byte(8'h06);
      send_frame();
      begin_frame(verdicts.codes.list_code, 8'h07);
      queue_byte(8'd1);
      queue_byte(8'h05);
      queue_byte(8'h06);
      queue_byte(CHOICE_CAUSE);
      send_frame();
      begin_frame(verdicts.codes.list_code, 8'h08);
      queue_byte(8'd2);
      queue_byte(8'h09);
      queue_byte(CHOICE_OPTIONAL);
      send_frame();
      // list with the largest count
      begin_frame(verdicts.codes.list_code, 8'hC3);
      queue_byte(8'd255);
      for (i = 0; i < 255; i++) queue_byte(8'($urandom_range(2, 255)));
      send_frame();
      // unknown subtype
      begin_frame(8'hFF, 8'h3C);
      add_filler(2);
      send_frame();
      // largest declared length with no data behind it
      begin_frame(verdicts.codes.datablock_code, 8'h9A);
      add_block_header(FINAL_BLOCK_MARK, 32'($urandom), 16'hFFFF);
      send_frame();
   endtask

   // main sequence
   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.frame_byte = '0;
      req_if.frame_end = 1'b0;
      rsp_if.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_NORMAL_CODE;
      csr_wdata = '0;
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      holdoff_requests = 0;
      holdoff_served = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      drain();

      // reset codes, with the verdict channel held off at the start
      holdoff_requests++;
      run_random(300);

      // extreme code values
      program_codes(8'h00, 8'hFF, 8'h80);
      run_random(200);

      // stretch with no idling on either side
      program_codes(NORMAL_CODE_RESET, DATABLOCK_CODE_RESET, LIST_CODE_RESET);
      sender_steady = 1'b1;
      receiver_steady = 1'b1;
      run_random(200);
      drain();
      sender_steady = 1'b0;
      receiver_steady = 1'b0;

      // equal codes: normal wins over the others, data block over list
      program_codes(8'h05, 8'h05, 8'h05);
      run_random(100);
      program_codes(8'h09, 8'h07, 8'h07);
      run_random(100);

      // random codes
      program_codes(8'($urandom), 8'($urandom), 8'($urandom));
      run_random(150);

      // back to reset codes with a second hold-off
      program_codes(NORMAL_CODE_RESET, DATABLOCK_CODE_RESET, LIST_CODE_RESET);
      holdoff_requests++;
      run_random(100);

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (verdicts.failures == 0 && verdicts.pending_count() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/arfc_pkg.sv
hw/rtl/arfc_req_if.sv
hw/rtl/arfc_rsp_if.sv
hw/rtl/arfc_in_stage.sv
hw/rtl/arfc_frame_state.sv
hw/rtl/arfc_verdict.sv
hw/rtl/action_response_frame_checker.sv
verif/testbench.sv
